// ===== src/cxc_pkg.sv =====
`timescale 1ns / 1ps
// cxc_pkg: shared types, opcodes and codes for the execute core
package cxc_pkg;

   localparam int RegCount = 16;
   localparam int RegAddrW = $clog2(RegCount);

   // opcodes
   localparam logic [7:0] OpPortRead  = 8'h10;
   localparam logic [7:0] OpPortWrite = 8'h11;
   localparam logic [7:0] OpLoadSb    = 8'h14;
   localparam logic [7:0] OpLoadUb    = 8'h15;
   localparam logic [7:0] OpLoadSh    = 8'h16;
   localparam logic [7:0] OpLoadUh    = 8'h17;
   localparam logic [7:0] OpLoadSw    = 8'h18;
   localparam logic [7:0] OpLoadUw    = 8'h19;
   localparam logic [7:0] OpStoreB    = 8'h1C;
   localparam logic [7:0] OpStoreH    = 8'h1D;
   localparam logic [7:0] OpStoreW    = 8'h1E;
   localparam logic [7:0] OpAddImm    = 8'h20;
   localparam logic [7:0] OpAndImm    = 8'h21;
   localparam logic [7:0] OpOrImm     = 8'h22;
   localparam logic [7:0] OpXorImm    = 8'h23;
   localparam logic [7:0] OpUpperImm  = 8'h28;
   localparam logic [7:0] OpUpperIp   = 8'h29;
   localparam logic [7:0] OpJumpLink  = 8'h30;
   localparam logic [7:0] OpJumpReg   = 8'h31;
   localparam logic [7:0] OpCondLink  = 8'h32;
   localparam logic [7:0] OpCondReg   = 8'h33;
   localparam logic [7:0] OpRegAdd    = 8'h40;
   localparam logic [7:0] OpRegSub    = 8'h41;

   // access operations
   localparam logic [2:0] AccNone      = 3'd0;
   localparam logic [2:0] AccMemRead   = 3'd1;
   localparam logic [2:0] AccMemWrite  = 3'd2;
   localparam logic [2:0] AccPortRead  = 3'd3;
   localparam logic [2:0] AccPortWrite = 3'd4;

   // access sizes
   localparam logic [1:0] SizeByte = 2'd0;
   localparam logic [1:0] SizeHalf = 2'd1;
   localparam logic [1:0] SizeWord = 2'd2;

   // load data extension
   localparam logic [2:0] ExtFull  = 3'd0;
   localparam logic [2:0] ExtSbyte = 3'd1;
   localparam logic [2:0] ExtUbyte = 3'd2;
   localparam logic [2:0] ExtShalf = 3'd3;
   localparam logic [2:0] ExtUhalf = 3'd4;
   localparam logic [2:0] ExtSword = 3'd5;
   localparam logic [2:0] ExtUword = 3'd6;

   // flag select of register add/subtract
   localparam logic [1:0] FlagCarry = 2'd0;
   localparam logic [1:0] FlagLess  = 2'd1;
   localparam logic [1:0] FlagOvf   = 2'd2;
   localparam logic [1:0] FlagKeep  = 2'd3;

   typedef struct packed {
      logic [31:0]         ip;
      logic [7:0]          cond;
      logic                pend;
      logic [RegAddrW-1:0] pend_dest;
      logic [2:0]          pend_ext;
      logic                halt;
   } core_state_type;

   typedef struct packed {
      logic                we;
      logic [RegAddrW-1:0] addr;
      logic [31:0]         data;
   } rf_write_type;

   typedef struct packed {
      logic        fetch_ready;
      logic [31:0] fetch_address;
      logic [2:0]  access_op;
      logic [1:0]  access_size;
      logic [31:0] access_address;
      logic [31:0] store_data;
      logic [7:0]  condition_bits;
      logic        halted;
   } rsp_type;

endpackage

// ===== src/cxc_req_if.sv =====
`timescale 1ns / 1ps
// cxc_req_if: input channel carrying instruction words and read data
interface cxc_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] word;

   modport source (output valid, output kind, output word, input ready);
   modport sink (input valid, input kind, input word, output ready);
endinterface

// ===== src/cxc_rsp_if.sv =====
`timescale 1ns / 1ps
// cxc_rsp_if: result channel carrying fetch, access and status fields
interface cxc_rsp_if;
   logic        valid;
   logic        ready;
   logic        fetch_ready;
   logic [31:0] fetch_address;
   logic [2:0]  access_op;
   logic [1:0]  access_size;
   logic [31:0] access_address;
   logic [31:0] store_data;
   logic [7:0]  condition_bits;
   logic        halted;

   modport source (output valid, output fetch_ready, output fetch_address, output access_op,
                   output access_size, output access_address, output store_data,
                   output condition_bits, output halted, input ready);
   modport sink (input valid, input fetch_ready, input fetch_address, input access_op,
                 input access_size, input access_address, input store_data,
                 input condition_bits, input halted, output ready);
endinterface

// ===== src/cxc_regfile.sv =====
`timescale 1ns / 1ps
// cxc_regfile: data register file, one write port and two registered read ports
module cxc_regfile (
   input  logic                          clock,
   input  logic                          reset,
   input  cxc_pkg::rf_write_type         wr,
   input  logic                          rd_en,
   input  logic [cxc_pkg::RegAddrW-1:0]  rd_addr_b,
   input  logic [cxc_pkg::RegAddrW-1:0]  rd_addr_x,
   output logic [31:0]                   rd_b,
   output logic [31:0]                   rd_x
);

   logic [31:0]                  regs_ff [cxc_pkg::RegCount];
   logic [cxc_pkg::RegCount-1:0] valid_ff;
   logic [31:0]                  rd_b_ff;
   logic [31:0]                  rd_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // write-first read so that a transaction sees the one committing ahead of it
   always_ff @(posedge clock) begin
      if (wr.we) begin
         regs_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         if (wr.we && wr.addr == rd_addr_b) begin
            rd_b_ff <= wr.data;
         end else begin
            rd_b_ff <= valid_ff[rd_addr_b] ? regs_ff[rd_addr_b] : '0;
         end
         if (wr.we && wr.addr == rd_addr_x) begin
            rd_x_ff <= wr.data;
         end else begin
            rd_x_ff <= valid_ff[rd_addr_x] ? regs_ff[rd_addr_x] : '0;
         end
      end
   end

   assign rd_b = rd_b_ff;
   assign rd_x = rd_x_ff;

endmodule

// ===== src/cxc_exec.sv =====
`timescale 1ns / 1ps
// cxc_exec: decode, ALU, branch and access logic of one transaction
module cxc_exec (
   input  logic                   kind,
   input  logic [31:0]            word,
   input  logic [31:0]            src_b,
   input  logic [31:0]            src_x,
   input  cxc_pkg::core_state_type cur,
   output cxc_pkg::core_state_type nxt,
   output cxc_pkg::rf_write_type   wr,
   output cxc_pkg::rsp_type        rsp
);

   logic [7:0]                   op;
   logic [cxc_pkg::RegAddrW-1:0] fa;
   logic [cxc_pkg::RegAddrW-1:0] fb;
   logic [31:0]                  i16;
   logic [31:0]                  i20;
   logic [31:0]                  ip4;
   logic [31:0]                  upper;
   logic                         taken;
   logic [31:0]                  load_val;
   logic [31:0]                  y2;
   logic [31:0]                  sum_r;
   logic [31:0]                  sum_xy;
   logic                         ovf_xy;
   logic                         ovf_r;
   logic [2:0]                   tc;
   logic                         ntc;
   logic                         sc;
   logic                         flag;
   logic [2:0]                   aop;
   logic [1:0]                   asz;
   logic [31:0]                  aad;
   logic [31:0]                  sdat;

   assign op    = word[7:0];
   assign fa    = word[11:8];
   assign fb    = word[15:12];
   assign i16   = {{16{word[23]}}, word[23:16], word[31:24]};
   assign i20   = {{12{word[15]}}, word[15:12], word[23:16], word[31:24]};
   assign ip4   = cur.ip + 32'd4;
   assign upper = {i16[15:0], src_x[15:0]};
   assign taken = cur.cond[word[14:12]] ^ word[15];

   // register add/subtract
   assign y2     = (op == cxc_pkg::OpRegSub) ? (32'd0 - src_x) : src_x;
   assign sum_r  = src_b + y2;
   assign sum_xy = src_b + src_x;
   assign ovf_xy = (src_b[31] == src_x[31]) && (sum_xy[31] != src_b[31]);
   assign ovf_r  = (src_b[31] == y2[31]) && (sum_r[31] != src_b[31]);
   assign tc     = word[30:28];
   assign ntc    = word[31];
   assign sc     = cur.cond[word[26:24]] ^ word[27];

   always_comb begin
      case (word[17:16])
         cxc_pkg::FlagCarry: flag = (sum_r < src_b);
         cxc_pkg::FlagLess:  flag = ovf_xy ^ sum_xy[31];
         cxc_pkg::FlagOvf:   flag = ovf_r;
         cxc_pkg::FlagKeep:  flag = cur.cond[tc] ^ ntc;
         default:            flag = 1'b0;
      endcase
   end

   always_comb begin
      case (cur.pend_ext)
         cxc_pkg::ExtSbyte: load_val = {{24{word[7]}}, word[7:0]};
         cxc_pkg::ExtUbyte: load_val = {24'd0, word[7:0]};
         cxc_pkg::ExtShalf: load_val = {{16{word[15]}}, word[15:0]};
         cxc_pkg::ExtUhalf: load_val = {16'd0, word[15:0]};
         default:           load_val = word;
      endcase
   end

   always_comb begin
      nxt     = cur;
      wr.we   = 1'b0;
      wr.addr = fa;
      wr.data = '0;
      aop     = cxc_pkg::AccNone;
      asz     = cxc_pkg::SizeByte;
      aad     = '0;
      sdat    = '0;
      if (!cur.halt) begin
         if (kind) begin
            if (cur.pend) begin
               wr.we    = (cur.pend_dest != '0);
               wr.addr  = cur.pend_dest;
               wr.data  = load_val;
               nxt.pend = 1'b0;
            end
         end else if (!cur.pend) begin
            nxt.ip = ip4;
            case (op)
               cxc_pkg::OpJumpLink: begin
                  wr.we   = (fa != '0);
                  wr.data = ip4;
                  nxt.ip  = cur.ip + {i20[30:0], 1'b0};
               end
               cxc_pkg::OpJumpReg: begin
                  nxt.ip = cur.ip + {i20[30:0], 1'b0} + src_x;
               end
               cxc_pkg::OpCondLink: begin
                  if (taken) begin
                     wr.we   = (fa != '0);
                     wr.data = ip4;
                     nxt.ip  = cur.ip + {i16[30:0], 1'b0};
                  end
               end
               cxc_pkg::OpCondReg: begin
                  if (taken) begin
                     nxt.ip = cur.ip + {i16[30:0], 1'b0} + src_x;
                  end
               end
               cxc_pkg::OpPortRead: begin
                  aop = cxc_pkg::AccPortRead;
                  asz = cxc_pkg::SizeWord;
                  aad = src_b + i16;
                  nxt.pend      = 1'b1;
                  nxt.pend_dest = fa;
                  nxt.pend_ext  = cxc_pkg::ExtFull;
               end
               cxc_pkg::OpPortWrite: begin
                  aop  = cxc_pkg::AccPortWrite;
                  asz  = cxc_pkg::SizeWord;
                  aad  = src_b + i16;
                  sdat = src_x;
               end
               cxc_pkg::OpLoadSb, cxc_pkg::OpLoadUb, cxc_pkg::OpLoadSh,
               cxc_pkg::OpLoadUh, cxc_pkg::OpLoadSw, cxc_pkg::OpLoadUw: begin
                  aop = cxc_pkg::AccMemRead;
                  aad = src_b + i16;
                  nxt.pend      = 1'b1;
                  nxt.pend_dest = fa;
                  case (op)
                     cxc_pkg::OpLoadSb: begin
                        asz = cxc_pkg::SizeByte;
                        nxt.pend_ext = cxc_pkg::ExtSbyte;
                     end
                     cxc_pkg::OpLoadUb: begin
                        asz = cxc_pkg::SizeByte;
                        nxt.pend_ext = cxc_pkg::ExtUbyte;
                     end
                     cxc_pkg::OpLoadSh: begin
                        asz = cxc_pkg::SizeHalf;
                        nxt.pend_ext = cxc_pkg::ExtShalf;
                     end
                     cxc_pkg::OpLoadUh: begin
                        asz = cxc_pkg::SizeHalf;
                        nxt.pend_ext = cxc_pkg::ExtUhalf;
                     end
                     cxc_pkg::OpLoadSw: begin
                        asz = cxc_pkg::SizeWord;
                        nxt.pend_ext = cxc_pkg::ExtSword;
                     end
                     default: begin
                        asz = cxc_pkg::SizeWord;
                        nxt.pend_ext = cxc_pkg::ExtUword;
                     end
                  endcase
               end
               cxc_pkg::OpStoreB, cxc_pkg::OpStoreH, cxc_pkg::OpStoreW: begin
                  aop  = cxc_pkg::AccMemWrite;
                  aad  = src_b + i16;
                  sdat = src_x;
                  case (op)
                     cxc_pkg::OpStoreB: asz = cxc_pkg::SizeByte;
                     cxc_pkg::OpStoreH: asz = cxc_pkg::SizeHalf;
                     default:           asz = cxc_pkg::SizeWord;
                  endcase
               end
               cxc_pkg::OpAddImm: begin
                  wr.we   = (fa != '0);
                  wr.data = src_b + i16;
               end
               cxc_pkg::OpAndImm: begin
                  wr.we   = (fa != '0);
                  wr.data = src_b & i16;
               end
               cxc_pkg::OpOrImm: begin
                  wr.we   = (fa != '0);
                  wr.data = src_b | i16;
               end
               cxc_pkg::OpXorImm: begin
                  wr.we   = (fa != '0);
                  wr.data = src_b ^ i16;
               end
               cxc_pkg::OpUpperImm: begin
                  wr.we   = (fa != '0);
                  wr.data = upper;
               end
               cxc_pkg::OpUpperIp: begin
                  wr.we   = (fa != '0);
                  wr.data = upper + cur.ip;
               end
               cxc_pkg::OpRegAdd, cxc_pkg::OpRegSub: begin
                  // same target and source keeps its old value
                  wr.we   = (fa != '0) && (fa != fb);
                  wr.data = sum_r;
                  nxt.cond[tc] = word[18] ? ((flag ^ ntc) & sc) : ((flag ^ ntc) | sc);
               end
               default: begin
                  nxt.halt = 1'b1;
                  nxt.ip   = cur.ip;
               end
            endcase
         end
      end
      nxt.cond[0] = 1'b0;
   end

   assign rsp.fetch_ready    = !nxt.halt && !nxt.pend;
   assign rsp.fetch_address  = nxt.ip;
   assign rsp.access_op      = aop;
   assign rsp.access_size    = asz;
   assign rsp.access_address = aad;
   assign rsp.store_data     = sdat;
   assign rsp.condition_bits = nxt.cond;
   assign rsp.halted         = nxt.halt;

endmodule

// ===== src/custom_cpu_execute_core_top.sv =====
`timescale 1ns / 1ps
// custom_cpu_execute_core_top: execute core top level with channels and state
// Takes one transaction (instruction word or read data) per cycle while results are
// taken, and returns one result per transaction: the register file is read into the
// input register at acceptance, then decode, ALU and next state are worked out in a
// single pass into the result register when the transaction commits, which waits
// while an earlier result still waits on the output. A result waiting on the output
// holds the input only once the input register is also occupied, and a register
// written by one transaction is forwarded to the next at the register file read port.
module custom_cpu_execute_core_top (
   input logic      clock,
   input logic      reset,
   cxc_req_if.sink  req_chan,
   cxc_rsp_if.source rsp_chan
);

   logic                         in_valid_ff;
   logic                         in_kind_ff;
   logic [31:0]                  in_word_ff;
   logic                         out_valid_ff;
   cxc_pkg::rsp_type             out_ff;
   cxc_pkg::core_state_type      state_ff;
   cxc_pkg::core_state_type      state_in;
   cxc_pkg::rf_write_type        rf_wr;
   cxc_pkg::rf_write_type        rf_wr_commit;
   cxc_pkg::rsp_type             rsp_in;
   logic                         commit;
   logic                         accept;
   logic [cxc_pkg::RegAddrW-1:0] rd_addr_x;
   logic [31:0]                  src_b;
   logic [31:0]                  src_x;

   assign commit = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || commit;
   assign accept = req_chan.valid && req_chan.ready;

   // register writes only land when the transaction commits
   always_comb begin
      rf_wr_commit    = rf_wr;
      rf_wr_commit.we = rf_wr.we && commit;
   end

   // second read port serves the add/subtract source or the target register
   assign rd_addr_x = (req_chan.word[7:0] == cxc_pkg::OpRegAdd ||
                       req_chan.word[7:0] == cxc_pkg::OpRegSub) ?
                      req_chan.word[23:20] : req_chan.word[11:8];

   cxc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr_commit),
      .rd_en     (accept),
      .rd_addr_b (req_chan.word[15:12]),
      .rd_addr_x (rd_addr_x),
      .rd_b      (src_b),
      .rd_x      (src_x)
   );

   cxc_exec u_exec (
      .kind  (in_kind_ff),
      .word  (in_word_ff),
      .src_b (src_b),
      .src_x (src_x),
      .cur   (state_ff),
      .nxt   (state_in),
      .wr    (rf_wr),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (commit) begin
            in_valid_ff <= 1'b0;
         end
         if (commit) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_chan.kind;
         in_word_ff <= req_chan.word;
      end
      if (commit) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.fetch_ready    = out_ff.fetch_ready;
   assign rsp_chan.fetch_address  = out_ff.fetch_address;
   assign rsp_chan.access_op      = out_ff.access_op;
   assign rsp_chan.access_size    = out_ff.access_size;
   assign rsp_chan.access_address = out_ff.access_address;
   assign rsp_chan.store_data     = out_ff.store_data;
   assign rsp_chan.condition_bits = out_ff.condition_bits;
   assign rsp_chan.halted         = out_ff.halted;

   // halt is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |=> state_ff.halt)
      else $error("halt flag cleared");

   // no register writes once halted
   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |-> !rf_wr.we)
      else $error("register write while halted");

   // an instruction arriving while a read is pending leaves the pointer alone
   a_pend_ignore: assert property (@(posedge clock) disable iff (reset)
      commit && state_ff.pend && !in_kind_ff |=> $stable(state_ff.ip))
      else $error("instruction executed with read pending");

   // a memory read leaves the core waiting for its data
   a_read_pends: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_in.access_op == cxc_pkg::AccMemRead |=> state_ff.pend && !out_ff.fetch_ready)
      else $error("memory read did not set pending");

endmodule
